### rtl/collision_test_unit_defines.svh
// Assertion macros for the collision test unit.
// Depends on nothing; included by the top level.
`ifndef COLLISION_TEST_UNIT_DEFINES_SVH
`define COLLISION_TEST_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define CTU_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`else
`define CTU_ASSERT(label, clk, rst, prop, msg)
`endif
`ifndef SYNTHESIS
`define CTU_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CTU_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

### rtl/ctu_pkg.sv
// Shared types and constants for the collision test unit.
// Depends on nothing.
package ctu_pkg;
  localparam int CoordBits = 24;
  localparam int DiffBits  = CoordBits + 2;
  localparam int ProdBits  = 2 * DiffBits;
  localparam int SumBits   = ProdBits + 1;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [DiffBits-1:0]  diff_t;
  typedef logic signed [ProdBits-1:0]  prod_t;
  typedef logic signed [SumBits-1:0]   sum_t;

  typedef enum logic [2:0] {
    FN_CC      = 3'd0,
    FN_RR      = 3'd1,
    FN_CR      = 3'd2,
    FN_SEGSEG  = 3'd3,
    FN_SEGRECT = 3'd4,
    FN_PTCIRC  = 3'd5,
    FN_PTRECT  = 3'd6,
    FN_NONE    = 3'd7
  } func_t;

  typedef struct packed {
    func_t  func;
    coord_t ax, ay, bx, by, cx, cy, dx, dy;
  } query_t;

  // One segment pair: differences feeding the three cross products.
  typedef struct packed {
    diff_t rx, ry, sx, sy, qx, qy;
  } seg_t;

  // Products of one segment pair.
  typedef struct packed {
    prod_t syrx, sxry, sxqy, syqx, rxqy, ryqx;
  } segp_t;

  // Signed cross-product differences of one segment pair after the subtract.
  typedef struct packed {
    sum_t den, na, nb;
  } segs_t;
endpackage

### rtl/ctu_seg_lane.sv
// One segment-segment lane: products, cross sums, then the interval test.
// Depends on ctu_pkg.
module ctu_seg_lane (
  input  logic           clk,
  input  logic           en1,
  input  logic           en2,
  input  ctu_pkg::seg_t  seg,
  output logic           hit
);
  import ctu_pkg::*;

  segp_t p;
  segs_t s;

  // Stage: six products
  always_ff @(posedge clk) begin
    if (en1) begin
      p.syrx <= seg.sy * seg.rx;
      p.sxry <= seg.sx * seg.ry;
      p.sxqy <= seg.sx * seg.qy;
      p.syqx <= seg.sy * seg.qx;
      p.rxqy <= seg.rx * seg.qy;
      p.ryqx <= seg.ry * seg.qx;
    end
  end

  // Stage: cross-product differences
  always_ff @(posedge clk) begin
    if (en2) begin
      s.den <= SumBits'(p.syrx) - SumBits'(p.sxry);
      s.na  <= SumBits'(p.sxqy) - SumBits'(p.syqx);
      s.nb  <= SumBits'(p.rxqy) - SumBits'(p.ryqx);
    end
  end

  // Interval test on the registered sums
  function automatic logic in_unit(sum_t n, sum_t d);
    if (d > 0) return (n >= 0) && (n <= d);
    return (n <= 0) && (n >= d);
  endfunction

  assign hit = (s.den != 0) && in_unit(s.na, s.den) && in_unit(s.nb, s.den);
endmodule

### rtl/ctu_front.sv
// Front stage: operand differences, rectangle edges and clamping.
// Depends on ctu_pkg.
module ctu_front (
  input  logic            clk,
  input  logic            en,
  input  ctu_pkg::query_t q,
  output ctu_pkg::seg_t   seg [4],
  output ctu_pkg::diff_t  ddx,
  output ctu_pkg::diff_t  ddy,
  output ctu_pkg::diff_t  rad,
  output logic            simple_hit,
  output ctu_pkg::func_t  func
);
  import ctu_pkg::*;

  diff_t ax, ay, bx, by, cx, cy, dx, dy, rr, rb, tx, ty;
  diff_t ex [4], ey [4], fx [4], fy [4];
  logic  rr_hit, pr_hit;

  always_comb begin
    ax = DiffBits'(q.ax); ay = DiffBits'(q.ay);
    bx = DiffBits'(q.bx); by = DiffBits'(q.by);
    cx = DiffBits'(q.cx); cy = DiffBits'(q.cy);
    dx = DiffBits'(q.dx); dy = DiffBits'(q.dy);
    rr = cx + dx;
    rb = cy + dy;
    // clamp centre to rectangle
    tx = ax;
    if (ax < cx) tx = cx;
    else if (ax > rr) tx = rr;
    ty = ay;
    if (ay < cy) ty = cy;
    else if (ay > rb) ty = rb;
    rr_hit = !((cx >= ax + bx) || (rr <= ax) || (cy >= ay + by) || (rb <= ay));
    pr_hit = (ax >= cx) && (ax <= rr) && (ay >= cy) && (ay <= rb);
    // second segment per lane: plain or rectangle edges
    if (q.func == FN_SEGRECT) begin
      ex[0] = cx; ey[0] = cy; fx[0] = cx; fy[0] = rb;
      ex[1] = rr; ey[1] = cy; fx[1] = rr; fy[1] = rb;
      ex[2] = cx; ey[2] = cy; fx[2] = rr; fy[2] = cy;
      ex[3] = cx; ey[3] = rb; fx[3] = rr; fy[3] = rb;
    end else begin
      for (int i = 0; i < 4; i++) begin
        ex[i] = cx; ey[i] = cy; fx[i] = dx; fy[i] = dy;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        seg[i].rx <= bx - ax;
        seg[i].ry <= by - ay;
        seg[i].sx <= fx[i] - ex[i];
        seg[i].sy <= fy[i] - ey[i];
        seg[i].qx <= ax - ex[i];
        seg[i].qy <= ay - ey[i];
      end
      func <= q.func;
      unique case (q.func)
        FN_CR: begin
          ddx <= ax - tx; ddy <= ay - ty; rad <= bx;
        end
        FN_CC: begin
          ddx <= ax - cx; ddy <= ay - cy; rad <= bx + by;
        end
        default: begin
          ddx <= ax - cx; ddy <= ay - cy; rad <= bx;
        end
      endcase
      simple_hit <= (q.func == FN_RR) ? rr_hit : pr_hit;
    end
  end
endmodule

### rtl/collision_test_unit.sv
// Top level of the collision test unit: handshake, pipeline and result.
// Depends on ctu_pkg, ctu_front, ctu_seg_lane and the defines header.
//
// Four register stages: operand prep, products, cross sums, compare. One query
// is taken each cycle unless stalled. Its hit bit is valid once in the compare
// stage. The whole pipe advances only when its output is empty or being taken.
// A stalled output holds every stage, so nothing is lost or repeated.
`include "collision_test_unit_defines.svh"
module collision_test_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata: op_a_x, op_a_y, op_b_x, op_b_y, op_c_x, op_c_y, op_d_x, op_d_y
  input  logic [191:0] s_tdata,
  // tuser: func
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // tdata: hit (bit 0), zero fill
  output logic [7:0]  m_tdata
);
  import ctu_pkg::*;

  logic   adv;
  logic   v1, v2, v3;
  query_t q;
  seg_t   seg [4];
  diff_t  ddx, ddy, rad;
  logic   simple1, simple2, simple3;
  func_t  f1, f2, f3;
  prod_t  px, py, pr;
  sum_t   dsum, rsq;
  logic   lane_hit [4];
  logic   hit_r;
  logic   calc;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  always_comb begin
    q.func = func_t'(s_tuser);
    q.ax = s_tdata[0*CoordBits +: CoordBits];
    q.ay = s_tdata[1*CoordBits +: CoordBits];
    q.bx = s_tdata[2*CoordBits +: CoordBits];
    q.by = s_tdata[3*CoordBits +: CoordBits];
    q.cx = s_tdata[4*CoordBits +: CoordBits];
    q.cy = s_tdata[5*CoordBits +: CoordBits];
    q.dx = s_tdata[6*CoordBits +: CoordBits];
    q.dy = s_tdata[7*CoordBits +: CoordBits];
  end

  ctu_front u_front (
    .clk(clk), .en(adv), .q(q), .seg(seg), .ddx(ddx), .ddy(ddy), .rad(rad),
    .simple_hit(simple1), .func(f1)
  );

  for (genvar i = 0; i < 4; i++) begin : g_lane
    ctu_seg_lane u_lane (
      .clk(clk), .en1(adv), .en2(adv), .seg(seg[i]), .hit(lane_hit[i])
    );
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; m_tvalid <= 1'b0;
    end else if (adv) begin
      v1 <= s_tvalid; v2 <= v1; v3 <= v2; m_tvalid <= v3;
    end
  end

  // Distance stages: squares then sums
  always_ff @(posedge clk) begin
    if (adv) begin
      px <= ddx * ddx; py <= ddy * ddy; pr <= rad * rad;
      // circle-rect only needs a non-negative radius here
      simple2 <= (f1 == FN_CR) ? (rad >= 0) : simple1;
      f2 <= f1;
      dsum <= SumBits'(px) + SumBits'(py);
      rsq <= SumBits'(pr);
      simple3 <= simple2;
      f3 <= f2;
      hit_r <= calc;
    end
  end

  always_comb begin
    case (f3) inside
      FN_CC, FN_PTCIRC: calc = dsum < rsq;
      FN_CR:            calc = simple3 && (dsum <= rsq);
      FN_RR, FN_PTRECT: calc = simple3;
      FN_SEGSEG:        calc = lane_hit[0];
      FN_SEGRECT:       calc = lane_hit[0] || lane_hit[1] || lane_hit[2] || lane_hit[3];
      default:          calc = 1'b0;
    endcase
  end

  assign m_tdata = {7'b0, hit_r};

  `CTU_ASSERT(a_stall_hold, clk, rst, (m_tvalid && !m_tready) |=> $stable(m_tdata),
    "result changed while stalled")
  `CTU_ASSERT(a_ready, clk, rst, s_tready == (!m_tvalid || m_tready),
    "ready not tied to output slot")
  `CTU_ASSERT_RST(a_reset, clk, rst |=> !m_tvalid, "valid after reset")
endmodule
